// File: design/ss_pkg.sv
// ----------------------------------------------------------------------------
// ss_pkg
// Shared widths, command and status types for the primality round engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ss_pkg;
    localparam int NumBits = 32;
    localparam int CntW    = $clog2(NumBits + 1);

    typedef logic [NumBits-1:0] word_t;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;

    typedef struct packed {
        logic [2:0] op;
    } ss_cmd_t;

    typedef struct packed {
        logic busy;
        logic trivial;
        logic trivial_prime;
        logic round_ok;
    } ss_sts_t;
endpackage
`default_nettype wire

// File: design/solovay_strassen_prime_test.sv
// ----------------------------------------------------------------------------
// solovay_strassen_prime_test
// One Solovay-Strassen round per transaction; verdict on the last round.
// ----------------------------------------------------------------------------
// A round runs on one bit-serial remainder and shift-add multiply unit that
// the witness reduction, the Jacobi loop and the modular power share. Each
// Jacobi reduction step also removes the factors of two one at a time, and
// each exponent bit takes one modular multiply, or two on a set bit.
// Trivial candidates (below 4 or even) run no round; on the last round their
// verdict is registered and appears in the cycle after the transaction, and
// on an earlier round they are dropped. A new transaction is taken once the
// previous verdict has been delivered.
`default_nettype none
module solovay_strassen_prime_test
    import ss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [NumBits-1:0] candidate,
    input  wire logic [NumBits-1:0] random_value,
    input  wire logic               last_round,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    probably_prime
);
    ss_cmd_t cmd;
    ss_sts_t sts;

    ss_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .valid_in       (in_valid),
        .ready_in       (in_ready),
        .last_round     (last_round),
        .valid_out      (out_valid),
        .ready_out      (out_ready),
        .probably_prime (probably_prime),
        .cmd            (cmd),
        .sts            (sts)
    );

    ss_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .candidate    (candidate),
        .random_value (random_value),
        .cmd          (cmd),
        .sts          (sts)
    );
endmodule
`default_nettype wire

// File: design/ss_datapath.sv
// ----------------------------------------------------------------------------
// ss_datapath
// Witness reduction, Jacobi symbol and modular power, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ss_datapath
    import ss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [NumBits-1:0]   candidate,
    input  wire logic [NumBits-1:0]   random_value,
    input  wire ss_cmd_t              cmd,
    output ss_sts_t                   sts
);
    localparam logic [3:0] P_IDLE  = 4'd0;
    localparam logic [3:0] P_MODI  = 4'd1;
    localparam logic [3:0] P_MODS  = 4'd2;
    localparam logic [3:0] P_JEVEN = 4'd3;
    localparam logic [3:0] P_JSWAP = 4'd4;
    localparam logic [3:0] P_JMODI = 4'd5;
    localparam logic [3:0] P_JMODS = 4'd6;
    localparam logic [3:0] P_PBIT  = 4'd7;
    localparam logic [3:0] P_MULI  = 4'd8;
    localparam logic [3:0] P_MULS  = 4'd9;
    localparam logic [3:0] P_DONE  = 4'd10;

    localparam logic [1:0] M_WIT   = 2'd0;
    localparam logic [1:0] M_JAC   = 2'd1;
    localparam logic [1:0] M_SQR   = 2'd2;
    localparam logic [1:0] M_ACC   = 2'd3;

    logic [3:0]        ph_reg, ph_next;
    logic [1:0]        mop_reg, mop_next;
    word_t             n_reg, n_next;
    word_t             a_reg, a_next;
    word_t             x_reg, x_next;
    word_t             m_reg, m_next;
    logic              neg_reg, neg_next;
    word_t             base_reg, base_next;
    word_t             acc_reg, acc_next;
    word_t             e_reg, e_next;
    // shared remainder / multiply unit
    logic [NumBits:0]  rem_reg, rem_next;
    word_t             dvd_reg, dvd_next;
    word_t             dv_reg, dv_next;
    word_t             mx_reg, mx_next;
    word_t             my_reg, my_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              ok_reg, ok_next;

    logic [NumBits:0]  rsh, rdif;
    logic [NumBits:0]  msum, mdbl;
    word_t             jval;

    always_comb
    begin
        rsh  = {rem_reg[NumBits-1:0], dvd_reg[NumBits-1]};
        rdif = rsh - {1'b0, dv_reg};
        msum = {1'b0, rem_reg[NumBits-1:0]} + {1'b0, mx_reg};
        mdbl = {1'b0, mx_reg} + {1'b0, mx_reg};
        jval = neg_reg ? (n_reg - word_t'(1)) : word_t'(1);
    end

    always_comb
    begin
        ph_next = ph_reg; mop_next = mop_reg; n_next = n_reg; a_next = a_reg;
        x_next = x_reg; m_next = m_reg; neg_next = neg_reg; base_next = base_reg;
        acc_next = acc_reg; e_next = e_reg; rem_next = rem_reg; dvd_next = dvd_reg;
        dv_next = dv_reg; mx_next = mx_reg; my_next = my_reg; cnt_next = cnt_reg;
        ok_next = ok_reg;
        unique case (ph_reg)
            P_IDLE:
            begin
                if (cmd.op == OP_LOAD)
                begin
                    n_next   = candidate;
                    dvd_next = random_value;
                    dv_next  = candidate - word_t'(2);
                    mop_next = M_WIT;
                    ph_next  = P_MODI;
                end
            end
            P_MODI:
            begin
                rem_next = '0;
                cnt_next = CntW'(NumBits);
                ph_next  = P_MODS;
            end
            P_MODS:
            begin
                if (rdif[NumBits])
                    rem_next = rsh;
                else
                    rem_next = rdif;
                dvd_next = {dvd_reg[NumBits-2:0], 1'b0};
                cnt_next = cnt_reg - CntW'(1);
                if (cnt_reg == CntW'(1))
                begin
                    if (mop_reg == M_WIT)
                    begin
                        a_next   = (rdif[NumBits] ? rsh[NumBits-1:0] : rdif[NumBits-1:0])
                                   + word_t'(2);
                        x_next   = a_next;
                        m_next   = n_reg;
                        neg_next = 1'b0;
                        ph_next  = P_JEVEN;
                    end
                    else
                    begin
                        x_next  = rdif[NumBits] ? rsh[NumBits-1:0] : rdif[NumBits-1:0];
                        ph_next = P_JEVEN;
                    end
                end
            end
            P_JEVEN:
            begin
                if (x_reg == '0)
                begin
                    ok_next   = (m_reg == word_t'(1));
                    base_next = a_reg;
                    acc_next  = word_t'(1);
                    e_next    = (n_reg - word_t'(1)) >> 1;
                    ph_next   = P_PBIT;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                    if (m_reg[2:0] == 3'd3 || m_reg[2:0] == 3'd5)
                        neg_next = ~neg_reg;
                end
                else
                    ph_next = P_JSWAP;
            end
            P_JSWAP:
            begin
                x_next = m_reg;
                m_next = x_reg;
                if (x_reg[1:0] == 2'd3 && m_reg[1:0] == 2'd3)
                    neg_next = ~neg_reg;
                ph_next = P_JMODI;
            end
            P_JMODI:
            begin
                dvd_next = x_reg;
                dv_next  = m_reg;
                mop_next = M_JAC;
                ph_next  = P_MODI;
            end
            P_PBIT:
            begin
                if (e_reg == '0)
                begin
                    ok_next = ok_reg && (acc_reg == jval);
                    ph_next = P_DONE;
                end
                else if (e_reg[0])
                begin
                    mx_next  = acc_reg;
                    my_next  = base_reg;
                    mop_next = M_ACC;
                    ph_next  = P_MULI;
                end
                else
                begin
                    mx_next  = base_reg;
                    my_next  = base_reg;
                    mop_next = M_SQR;
                    ph_next  = P_MULI;
                end
            end
            P_MULI:
            begin
                rem_next = '0;
                ph_next  = P_MULS;
            end
            P_MULS:
            begin
                if (my_reg == '0)
                begin
                    if (mop_reg == M_ACC)
                    begin
                        acc_next = rem_reg[NumBits-1:0];
                        mx_next  = base_reg;
                        my_next  = base_reg;
                        mop_next = M_SQR;
                        ph_next  = P_MULI;
                    end
                    else
                    begin
                        base_next = rem_reg[NumBits-1:0];
                        e_next    = e_reg >> 1;
                        ph_next   = P_PBIT;
                    end
                end
                else
                begin
                    if (my_reg[0])
                    begin
                        if (msum >= {1'b0, n_reg})
                            rem_next = msum - {1'b0, n_reg};
                        else
                            rem_next = msum;
                    end
                    if (mdbl >= {1'b0, n_reg})
                        mx_next = NumBits'(mdbl - {1'b0, n_reg});
                    else
                        mx_next = mdbl[NumBits-1:0];
                    my_next = my_reg >> 1;
                end
            end
            P_DONE:
            begin
                ph_next = P_IDLE;
            end
            default:
            begin
                ph_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= P_IDLE;
            ok_reg <= 1'b0;
        end
        else
        begin
            ph_reg <= ph_next;
            ok_reg <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mop_reg <= mop_next; n_reg <= n_next; a_reg <= a_next; x_reg <= x_next;
        m_reg <= m_next; neg_reg <= neg_next; base_reg <= base_next;
        acc_reg <= acc_next; e_reg <= e_next; rem_reg <= rem_next;
        dvd_reg <= dvd_next; dv_reg <= dv_next; mx_reg <= mx_next;
        my_reg <= my_next; cnt_reg <= cnt_next;
    end

    always_comb
    begin
        sts.busy          = (ph_reg != P_IDLE);
        sts.trivial       = (candidate < word_t'(4)) || !candidate[0];
        sts.trivial_prime = (candidate == word_t'(2)) || (candidate == word_t'(3));
        sts.round_ok      = ok_reg;
    end
endmodule
`default_nettype wire

// File: design/ss_ctrl.sv
// ----------------------------------------------------------------------------
// ss_ctrl
// Handshake control, running pass flag and verdict register.
// ----------------------------------------------------------------------------
`default_nettype none
module ss_ctrl
    import ss_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    valid_in,
    output logic         ready_in,
    input  wire logic    last_round,
    output logic         valid_out,
    input  wire logic    ready_out,
    output logic         probably_prime,
    output ss_cmd_t      cmd,
    input  wire ss_sts_t sts
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       pass_reg, pass_next;
    logic       last_reg, last_next;
    logic       ov_reg, ov_next;
    logic       pp_reg, pp_next;
    logic       accept;

    assign ready_in       = (state_reg == S_IDLE) && !ov_reg;
    assign accept         = valid_in && ready_in;
    assign valid_out      = ov_reg;
    assign probably_prime = pp_reg;

    always_comb
    begin
        state_next = state_reg; pass_next = pass_reg; last_next = last_reg;
        ov_next = ov_reg; pp_next = pp_reg; cmd.op = OP_NONE;
        if (ov_reg && ready_out)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sts.trivial)
                    begin
                        if (last_round)
                        begin
                            ov_next   = 1'b1;
                            pp_next   = sts.trivial_prime;
                            pass_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.op     = OP_LOAD;
                        last_next  = last_round;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!sts.busy)
                begin
                    if (last_reg)
                    begin
                        ov_next   = 1'b1;
                        pp_next   = pass_reg && sts.round_ok;
                        pass_next = 1'b1;
                    end
                    else
                        pass_next = pass_reg && sts.round_ok;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b1;
            last_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            pp_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            last_reg  <= last_next;
            ov_reg    <= ov_next;
            pp_reg    <= pp_next;
        end
    end
endmodule
`default_nettype wire

// File: design/ss_checker.sv
// ----------------------------------------------------------------------------
// ss_checker
// Port-level checks for the primality round engine.
// ----------------------------------------------------------------------------
`default_nettype none
module ss_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic probably_prime
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(probably_prime))
        else $error("verdict dropped while stalled");

    a_no_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while verdict pending");

    a_drop_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("verdict repeated after transaction");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("verdict valid in reset");
endmodule
bind solovay_strassen_prime_test ss_checker u_ss_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .probably_prime(probably_prime)
);
`default_nettype wire
